// ===== rtl/core/esrd_pkg.sv =====
// ----------------------------------------------------------------------------
// esrd_pkg
// Shared types, constants and table functions of the shell density profile.
// ----------------------------------------------------------------------------
package esrd_pkg;

  typedef enum logic [1:0] {
    RGN_CORE  = 2'd0,
    RGN_SHELL = 2'd1,
    RGN_SOLV  = 2'd2
  } esrd_rgn_t;

  typedef struct packed {
    logic      vld;
    esrd_rgn_t rgn;
  } esrd_ctl_t;

  localparam int unsigned QBITS = 16;
  localparam int unsigned REM_W = 31;

  localparam logic [3:0] REG_CORE_RADIUS     = 4'd0;
  localparam logic [3:0] REG_SHELL_THICKNESS = 4'd1;
  localparam logic [3:0] REG_CORE_DENSITY    = 4'd2;
  localparam logic [3:0] REG_SHELL_DENSITY   = 4'd3;
  localparam logic [3:0] REG_INNER_FRACTION  = 4'd4;
  localparam logic [3:0] REG_OUTER_FRACTION  = 4'd5;
  localparam logic [3:0] REG_DECAY_RATE      = 4'd6;
  localparam logic [3:0] REG_SOLVENT_DENSITY = 4'd7;

  localparam logic [63:0] ONE60 = 64'h1000_0000_0000_0000;

  function automatic logic [63:0] mul_shr60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // Taylor sum of exp(-s) for a step s in Q4.60.
  function automatic logic [63:0] exp_decay(input logic [63:0] step);
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] term;
    pos  = ONE60;
    neg  = 64'd0;
    term = ONE60;
    for (int n = 1; n <= 40; n++) begin
      term = mul_shr60(term, step) / 64'(n);
      if (n % 2 == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    return pos - neg;
  endfunction

  function automatic logic [30:0] exp_entry(input logic [63:0] e, input int k);
    logic [63:0] v;
    v = ONE60;
    for (int j = 0; j < k; j++) begin
      v = mul_shr60(v, e);
    end
    return 31'((v + 64'h2000_0000) >> 30);
  endfunction

endpackage

// ===== rtl/core/esrd_div.sv =====
// ----------------------------------------------------------------------------
// esrd_div
// Pipelined restoring divider giving the 16-bit shell depth fraction.
// ----------------------------------------------------------------------------
module esrd_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  esrd_pkg::esrd_ctl_t ctl_in,
  input  logic [30:0]         rem_in,
  input  logic [30:0]         divisor,
  output esrd_pkg::esrd_ctl_t ctl_out,
  output logic [15:0]         quo_out
);
  import esrd_pkg::*;

  esrd_ctl_t        ctl_r [QBITS];
  logic [REM_W-1:0] rem_r [QBITS];
  logic [QBITS-1:0] quo_r [QBITS];

  for (genvar k = 0; k < QBITS; k++) begin : g_stage
    esrd_ctl_t        ctl_prev;
    logic [REM_W-1:0] rem_prev;
    logic [QBITS-1:0] quo_prev;
    logic [REM_W:0]   shl;
    logic             ge;
    logic [REM_W:0]   rem_nxt;

    if (k == 0) begin : g_first
      assign ctl_prev = ctl_in;
      assign rem_prev = rem_in;
      assign quo_prev = '0;
    end else begin : g_next
      assign ctl_prev = ctl_r[k-1];
      assign rem_prev = rem_r[k-1];
      assign quo_prev = quo_r[k-1];
    end

    always_comb begin
      shl     = {rem_prev, 1'b0};
      ge      = shl >= {1'b0, divisor};
      rem_nxt = ge ? (shl - {1'b0, divisor}) : shl;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k].vld <= 1'b0;
      end else if (en) begin
        ctl_r[k].vld <= ctl_prev.vld;
      end
      if (en) begin
        ctl_r[k].rgn <= ctl_prev.rgn;
        rem_r[k]     <= rem_nxt[REM_W-1:0];
        quo_r[k]     <= {quo_prev[QBITS-2:0], ge};
      end
    end
  end

  assign ctl_out = ctl_r[QBITS-1];
  assign quo_out = quo_r[QBITS-1];

endmodule

// ===== rtl/core/exp_shell_radial_density_profile.sv =====
// ----------------------------------------------------------------------------
// exp_shell_radial_density_profile
// Density of a core with an exponential shell at a given radius.
//
//   channel | direction | ports
//   --------+-----------+----------------------------------------
//   in      | input     | in_valid, in_stall, in_radius
//   out     | output    | out_valid, out_stall, out_density
//   cfg     | input     | cfg_valid, cfg_ready, cfg_index, cfg_wdata
//
// One transaction enters per cycle unless the output stalls; each result
// passes 25 register stages: the input register, the 16-stage divider, the
// exp interpolation and blend multiplier stages and the output register.
// Reset is synchronous; it clears valid bits and resets the config registers.
// A stall with out_valid high freezes the pipeline, and in_stall follows it.
// ----------------------------------------------------------------------------
module exp_shell_radial_density_profile #(
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_radius,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_density,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import esrd_pkg::*;

  localparam int          IW   = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int          PW   = 25 + IW;
  localparam logic [63:0] HALF = 64'h8000_0000_0000_0000;
  localparam logic [63:0] DEP  = 64'(EXP_TABLE_DEPTH);
  localparam logic [63:0] STEP = (HALF / DEP) * 64'd4 + ((HALF % DEP) * 64'd4) / DEP;
  localparam logic [63:0] EDEC = exp_decay(STEP);

  logic [30:0] rom_c [EXP_TABLE_DEPTH+1];
  for (genvar k = 0; k <= EXP_TABLE_DEPTH; k++) begin : g_rom
    assign rom_c[k] = exp_entry(EDEC, k);
  end

  logic [30:0] core_radius_r;
  logic [30:0] shell_thickness_r;
  logic [31:0] core_density_r;
  logic [31:0] shell_density_r;
  logic [16:0] inner_fraction_r;
  logic [16:0] outer_fraction_r;
  logic [23:0] decay_rate_r;
  logic [31:0] solvent_density_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      core_radius_r     <= 31'd65536;
      shell_thickness_r <= 31'd65536;
      core_density_r    <= '0;
      shell_density_r   <= '0;
      inner_fraction_r  <= '0;
      outer_fraction_r  <= '0;
      decay_rate_r      <= '0;
      solvent_density_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CORE_RADIUS:     core_radius_r     <= cfg_wdata[30:0];
        REG_SHELL_THICKNESS: shell_thickness_r <= cfg_wdata[30:0];
        REG_CORE_DENSITY:    core_density_r    <= cfg_wdata;
        REG_SHELL_DENSITY:   shell_density_r   <= cfg_wdata;
        REG_INNER_FRACTION:  inner_fraction_r  <= cfg_wdata[16:0];
        REG_OUTER_FRACTION:  outer_fraction_r  <= cfg_wdata[16:0];
        REG_DECAY_RATE:      decay_rate_r      <= cfg_wdata[23:0];
        REG_SOLVENT_DENSITY: solvent_density_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Blended shell densities follow the registers through the product, eta and base/diff registers.
  logic [16:0]        fin_c;
  logic [16:0]        fout_c;
  logic signed [49:0] pin_sol_r;
  logic signed [49:0] pin_sh_r;
  logic signed [49:0] pout_sol_r;
  logic signed [49:0] pout_sh_r;
  logic signed [50:0] sin_c;
  logic signed [50:0] sout_c;
  logic signed [31:0] eta_in_r;
  logic signed [31:0] eta_out_r;
  logic signed [32:0] base_r;
  logic signed [32:0] diff_r;

  always_comb begin
    fin_c  = (inner_fraction_r > 17'd65536) ? 17'd65536 : inner_fraction_r;
    fout_c = (outer_fraction_r > 17'd65536) ? 17'd65536 : outer_fraction_r;
    sin_c  = 51'(pin_sol_r) + 51'(pin_sh_r);
    sout_c = 51'(pout_sol_r) + 51'(pout_sh_r);
  end

  always_ff @(posedge clk) begin
    pin_sol_r  <= $signed({1'b0, fin_c}) * $signed(solvent_density_r);
    pin_sh_r   <= $signed({1'b0, 17'd65536 - fin_c}) * $signed(shell_density_r);
    pout_sol_r <= $signed({1'b0, fout_c}) * $signed(solvent_density_r);
    pout_sh_r  <= $signed({1'b0, 17'd65536 - fout_c}) * $signed(shell_density_r);
    eta_in_r   <= sin_c[47:16];
    eta_out_r  <= sout_c[47:16];
    if (decay_rate_r[23]) begin
      base_r <= 33'(eta_in_r);
      diff_r <= 33'(eta_out_r) - 33'(eta_in_r);
    end else begin
      base_r <= 33'(eta_out_r);
      diff_r <= 33'(eta_in_r) - 33'(eta_out_r);
    end
  end

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Input stage: magnitude and region.
  logic [31:0] mag_c;
  logic [31:0] lim_c;
  esrd_ctl_t   s0_ctl_nxt;
  esrd_ctl_t   s0_ctl_r;
  logic [30:0] s0_rem_r;

  always_comb begin
    mag_c          = in_radius[31] ? (32'd0 - in_radius) : in_radius;
    lim_c          = {1'b0, core_radius_r} + {1'b0, shell_thickness_r};
    s0_ctl_nxt.vld = in_valid;
    if (mag_c < {1'b0, core_radius_r}) begin
      s0_ctl_nxt.rgn = RGN_CORE;
    end else if (mag_c < lim_c) begin
      s0_ctl_nxt.rgn = RGN_SHELL;
    end else begin
      s0_ctl_nxt.rgn = RGN_SOLV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_ctl_r.vld <= 1'b0;
    end else if (adv) begin
      s0_ctl_r.vld <= s0_ctl_nxt.vld;
    end
    if (adv) begin
      s0_ctl_r.rgn <= s0_ctl_nxt.rgn;
      s0_rem_r     <= mag_c[30:0] - core_radius_r;
    end
  end

  esrd_ctl_t   dv_ctl;
  logic [15:0] dv_quo;

  esrd_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .ctl_in  (s0_ctl_r),
    .rem_in  (s0_rem_r),
    .divisor (shell_thickness_r),
    .ctl_out (dv_ctl),
    .quo_out (dv_quo)
  );

  esrd_ctl_t          a_ctl_r, b_ctl_r, c_ctl_r, d_ctl_r, e_ctl_r, f_ctl_r, g_ctl_r;
  logic [16:0]        a_w_r, b_w_r, c_w_r, d_w_r, e_w_r;
  logic [40:0]        a_tp_r;
  logic [IW-1:0]      b_idx_r;
  logic [20:0]        b_r_r, c_r_r;
  logic               b_zero_r, c_zero_r, d_zero_r;
  logic [30:0]        c_hi_r, c_lo_r, d_hi_r;
  logic [51:0]        d_dp_r;
  logic [30:0]        e_e_r;
  logic [31:0]        f_g_r;
  logic signed [65:0] g_p_r;

  logic [23:0]   amag_c;
  logic [16:0]   xm_c;
  logic [16:0]   w_c;
  logic [PW-1:0] p_c;
  logic          zero_c;
  logic [IW-1:0] idx_c;
  logic [IW-1:0] idx1_c;
  logic [51:0]   dp_c;
  logic [47:0]   gw_c;

  always_comb begin
    amag_c = decay_rate_r[23] ? (24'd0 - decay_rate_r) : decay_rate_r;
    xm_c   = decay_rate_r[23] ? (17'd65536 - {1'b0, dv_quo}) : {1'b0, dv_quo};
    w_c    = decay_rate_r[23] ? {1'b0, dv_quo} : (17'd65536 - {1'b0, dv_quo});
    p_c    = PW'(a_tp_r[40:16]) * PW'(EXP_TABLE_DEPTH);
    zero_c = PW'(p_c[PW-1:21]) >= PW'(EXP_TABLE_DEPTH);
    idx_c  = zero_c ? '0 : p_c[IW+20:21];
    idx1_c = b_idx_r + IW'(1);
    dp_c   = 52'(c_hi_r - c_lo_r) * 52'(c_r_r);
    gw_c   = 48'(e_w_r) * 48'(e_e_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r.vld <= 1'b0;
      b_ctl_r.vld <= 1'b0;
      c_ctl_r.vld <= 1'b0;
      d_ctl_r.vld <= 1'b0;
      e_ctl_r.vld <= 1'b0;
      f_ctl_r.vld <= 1'b0;
      g_ctl_r.vld <= 1'b0;
    end else if (adv) begin
      a_ctl_r.vld <= dv_ctl.vld;
      b_ctl_r.vld <= a_ctl_r.vld;
      c_ctl_r.vld <= b_ctl_r.vld;
      d_ctl_r.vld <= c_ctl_r.vld;
      e_ctl_r.vld <= d_ctl_r.vld;
      f_ctl_r.vld <= e_ctl_r.vld;
      g_ctl_r.vld <= f_ctl_r.vld;
    end
    if (adv) begin
      a_ctl_r.rgn <= dv_ctl.rgn;
      a_w_r       <= w_c;
      a_tp_r      <= 41'(xm_c) * 41'(amag_c);

      b_ctl_r.rgn <= a_ctl_r.rgn;
      b_w_r       <= a_w_r;
      b_idx_r     <= idx_c;
      b_r_r       <= p_c[20:0];
      b_zero_r    <= zero_c;

      c_ctl_r.rgn <= b_ctl_r.rgn;
      c_w_r       <= b_w_r;
      c_hi_r      <= rom_c[b_idx_r];
      c_lo_r      <= rom_c[idx1_c];
      c_r_r       <= b_r_r;
      c_zero_r    <= b_zero_r;

      d_ctl_r.rgn <= c_ctl_r.rgn;
      d_w_r       <= c_w_r;
      d_hi_r      <= c_hi_r;
      d_dp_r      <= dp_c;
      d_zero_r    <= c_zero_r;

      e_ctl_r.rgn <= d_ctl_r.rgn;
      e_w_r       <= d_w_r;
      e_e_r       <= d_zero_r ? '0 : (d_hi_r - d_dp_r[51:21]);

      f_ctl_r.rgn <= e_ctl_r.rgn;
      f_g_r       <= gw_c[47:16];

      g_ctl_r.rgn <= f_ctl_r.rgn;
      g_p_r       <= diff_r * $signed({1'b0, f_g_r});
    end
  end

  logic signed [36:0] sum_c;
  logic [31:0]        sat_c;
  logic [31:0]        res_c;

  always_comb begin
    sum_c = 37'(base_r) + 37'($signed(g_p_r[65:30]));
    if (sum_c > 37'sd2147483647) begin
      sat_c = 32'h7FFF_FFFF;
    end else if (sum_c < -37'sd2147483648) begin
      sat_c = 32'h8000_0000;
    end else begin
      sat_c = sum_c[31:0];
    end
    unique case (g_ctl_r.rgn)
      RGN_CORE:  res_c = core_density_r;
      RGN_SHELL: res_c = sat_c;
      default:   res_c = solvent_density_r;
    endcase
  end

  logic        out_valid_r;
  logic [31:0] out_density_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= g_ctl_r.vld;
    end
    if (adv) begin
      out_density_r <= res_c;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_density = out_density_r;

endmodule

// ===== tb/exp_shell_radial_density_profile_tb.sv =====
// ----------------------------------------------------------------------------
// exp_shell_radial_density_profile_tb
// Self-checking bench for the exponential shell density profile. Radii are
// driven through the input channel while a local predictor computes each
// density; results are compared in order, under random idling and stalls but for
// the full-rate phase, across several register settings written between phases.
// ----------------------------------------------------------------------------
module exp_shell_radial_density_profile_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import esrd_pkg::*;

  localparam int DEPTH = 256;
  localparam int LATENCY = 25;
  localparam longint CYCLE_LIMIT = 1500000;
  localparam logic [3:0] REG_UNKNOWN = 4'd9;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_radius;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_density;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_index;
  logic [31:0] cfg_wdata;

  exp_shell_radial_density_profile #(.EXP_TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_radius(in_radius),
    .out_valid(out_valid), .out_stall(out_stall), .out_density(out_density),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the configuration registers.
  logic [30:0] sh_core;
  logic [30:0] sh_thick;
  logic [31:0] sh_core_den;
  logic [31:0] sh_shell_den;
  logic [16:0] sh_fin;
  logic [16:0] sh_fout;
  logic [23:0] sh_alpha;
  logic [31:0] sh_solv_den;

  logic [31:0] exp_rom [0:DEPTH];
  logic [31:0] density_q[$];
  int     errors;
  int     n_sent;
  int     n_checked;
  longint cycles;
  bit     idle_en;

  initial begin
    clk = 1'b0;
  end
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [63:0] mulshift(input logic [63:0] a, input logic [63:0] b,
                                           input int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p >> s);
  endfunction

  task automatic build_exp_rom();
    logic [63:0] stp;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] v;
    stp = ((64'h8000_0000_0000_0000 / DEPTH) * 4) + (((64'h8000_0000_0000_0000 % DEPTH) * 4)
          / DEPTH);
    pos = 64'h1000_0000_0000_0000;
    neg = 0;
    term = 64'h1000_0000_0000_0000;
    for (int n = 1; n <= 40; n++) begin
      term = mulshift(term, stp, 60) / 64'(n);
      if (n % 2 == 1) neg += term;
      else pos += term;
    end
    e = pos - neg;
    v = 64'h1000_0000_0000_0000;
    exp_rom[0] = 32'((v + 64'h2000_0000) >> 30);
    for (int k = 1; k <= DEPTH; k++) begin
      v = mulshift(v, e, 60);
      exp_rom[k] = 32'((v + 64'h2000_0000) >> 30);
    end
  endtask

  function automatic longint solvent_blend(input logic [16:0] f);
    longint fr;
    longint acc;
    fr = (f > 17'd65536) ? 65536 : longint'(f);
    acc = fr * longint'($signed(sh_solv_den)) + (65536 - fr) * longint'($signed(sh_shell_den));
    return acc >>> 16;
  endfunction

  function automatic logic [31:0] profile_density(input logic [31:0] radius);
    logic [63:0] a;
    logic [63:0] x;
    logic [63:0] w;
    logic [63:0] t;
    logic [63:0] g;
    logic [63:0] p;
    logic [63:0] i;
    logic [63:0] r;
    logic [63:0] ev;
    longint e_in;
    longint e_out;
    longint alpha;
    longint base;
    longint diff;
    longint res;
    a = radius[31] ? 64'((~{32'd0, radius} + 1) & 64'hFFFF_FFFF) : {32'd0, radius};
    if (a < 64'(sh_core)) return sh_core_den;
    if (a >= 64'(sh_core) + 64'(sh_thick)) return sh_solv_den;
    x = ((a - 64'(sh_core)) << 16) / 64'(sh_thick);
    e_in = solvent_blend(sh_fin);
    e_out = solvent_blend(sh_fout);
    alpha = longint'($signed(sh_alpha));
    if (alpha < 0) begin
      w = x;
      t = ((65536 - x) * 64'(-alpha)) >> 16;
      base = e_in;
      diff = e_out - e_in;
    end else begin
      w = 65536 - x;
      t = (x * 64'(alpha)) >> 16;
      base = e_out;
      diff = e_in - e_out;
    end
    p = t * DEPTH;
    i = p >> 21;
    r = p & 64'h1F_FFFF;
    if (i >= DEPTH) ev = 0;
    else ev = 64'(exp_rom[i]) - (((64'(exp_rom[i]) - 64'(exp_rom[i + 1])) * r) >> 21);
    g = (w * ev) >> 16;
    res = base + ((diff * longint'(g)) >>> 30);
    if (res > 64'sd2147483647) res = 2147483647;
    if (res < -64'sd2147483648) res = -2147483648;
    return res[31:0];
  endfunction

  task automatic write_reg(input logic [3:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_CORE_RADIUS:     sh_core = value[30:0];
      REG_SHELL_THICKNESS: sh_thick = value[30:0];
      REG_CORE_DENSITY:    sh_core_den = value;
      REG_SHELL_DENSITY:   sh_shell_den = value;
      REG_INNER_FRACTION:  sh_fin = value[16:0];
      REG_OUTER_FRACTION:  sh_fout = value[16:0];
      REG_DECAY_RATE:      sh_alpha = value[23:0];
      REG_SOLVENT_DENSITY: sh_solv_den = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic setup(input logic [31:0] core, input logic [31:0] thick,
                       input logic [31:0] cden, input logic [31:0] sden,
                       input logic [31:0] fin, input logic [31:0] fout,
                       input logic [31:0] alpha, input logic [31:0] solv);
    write_reg(REG_CORE_RADIUS, core);
    write_reg(REG_SHELL_THICKNESS, thick);
    write_reg(REG_CORE_DENSITY, cden);
    write_reg(REG_SHELL_DENSITY, sden);
    write_reg(REG_INNER_FRACTION, fin);
    write_reg(REG_OUTER_FRACTION, fout);
    write_reg(REG_DECAY_RATE, alpha);
    write_reg(REG_SOLVENT_DENSITY, solv);
  endtask

  // Called at a falling edge; returns at a falling edge after acceptance with
  // valid still high, so transactions can follow back to back.
  task automatic send_radius(input logic [31:0] radius);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_radius <= radius;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    density_q.push_back(profile_density(radius));
    n_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (density_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] random_radius();
    logic [31:0] span;
    logic [31:0] base;
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: begin
        span = 32'(sh_thick) + 32'd4;
        base = 32'(sh_core) - 32'd2 + (span == 0 ? 32'd0 : $urandom() % span);
        return $urandom_range(0, 3) == 0 ? -base : base;
      end
    endcase
  endfunction

  task automatic test_reset_defaults();
    logic [31:0] pts [0:5] = '{32'h0, 32'h0000_8000, 32'h0001_0000, 32'h0001_8000,
                              32'h0002_0000, 32'hFFFE_8000};
    foreach (pts[k]) send_radius(pts[k]);
    drain();
  endtask

  task automatic test_directed_regions();
    logic [31:0] pts [0:11] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                               32'h0002_FFFF, 32'h0003_0000, 32'h0003_0001, 32'h0004_0000,
                               32'h0004_FFFF, 32'h0005_0000, 32'hFFFC_0000, 32'hFFFF_FFFF};
    setup(32'h0003_0000, 32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_4000,
          32'h0001_0000, 32'hFF80_0000, 32'h0123_4567);
    foreach (pts[k]) send_radius(pts[k]);
    drain();
    // Positive alpha, fractions above one, large exponent, oversized values.
    setup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_FFFF,
          32'hFFFF_FFFF, 32'h007F_FFFF, 32'h8000_0000);
    foreach (pts[k]) send_radius(pts[k]);
    drain();
    write_reg(REG_UNKNOWN, 32'h1234_5678);
    // Zero thickness removes the shell.
    setup(32'h0001_0000, 32'h0, 32'h0100_0000, 32'h0200_0000, 32'h0, 32'h0, 32'h0,
          32'h0300_0000);
    foreach (pts[k]) send_radius(pts[k]);
    drain();
  endtask

  task automatic test_random_settings(input int items);
    for (int s = 0; s < 6; s++) begin
      setup($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h0008_0000),
            s == 5 ? 32'h0 : ($urandom_range(0, 3) == 0 ? $urandom()
                                                        : $urandom_range(1, 32'h0008_0000)),
            $urandom(), $urandom(), $urandom_range(0, 70000), $urandom_range(0, 70000),
            $urandom_range(0, 1) ? $urandom() : 32'($signed($urandom_range(0, 2000)) - 1000),
            $urandom());
      for (int k = 0; k < items; k++) begin
        send_radius(random_radius());
        if (k == items / 2 && s == 2) drain();
      end
      drain();
    end
  endtask

  task automatic test_full_rate(input int items);
    idle_en = 1'b0;
    setup(32'h0000_8000, 32'h0004_0000, $urandom(), $urandom(), $urandom_range(0, 65536),
          $urandom_range(0, 65536), $urandom(), $urandom());
    for (int k = 0; k < items; k++) send_radius(random_radius());
    drain();
  endtask

  // Output stall generator with random bursts.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_en && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("exp_shell_radial_density_profile verification failed");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (density_q.size() == 0) begin
        $display("%0t: unexpected transaction, actual %h", $time, out_density);
        errors++;
      end else begin
        if (out_density !== density_q[0]) begin
          $display("%0t: density mismatch, expected %h actual %h", $time, density_q[0],
                   out_density);
          errors++;
        end
        void'(density_q.pop_front());
        n_checked++;
      end
    end
  end

  initial begin
    errors = 0;
    n_sent = 0;
    n_checked = 0;
    cycles = 0;
    idle_en = 1'b1;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_radius = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    sh_core = 31'd65536;
    sh_thick = 31'd65536;
    sh_core_den = 0;
    sh_shell_den = 0;
    sh_fin = 0;
    sh_fout = 0;
    sh_alpha = 0;
    sh_solv_den = 0;
    build_exp_rom();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_directed_regions();
    test_random_settings(250);
    test_full_rate(200);
    if (density_q.size() != 0) begin
      $display("%0d expected transactions never arrived.", density_q.size());
      errors++;
    end
    $display("Sent %0d radii over reset, directed and random settings; checked %0d.",
             n_sent, n_checked);
    if (errors == 0) begin
      $display("exp_shell_radial_density_profile verification clean");
    end else begin
      $display("exp_shell_radial_density_profile verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/esrd_pkg.sv
rtl/core/esrd_div.sv
rtl/core/exp_shell_radial_density_profile.sv
tb/exp_shell_radial_density_profile_tb.sv
